@@ rtl/jbt_pkg.sv @@
// Shared types, codes and character tables for the JSON byte tokenizer.
// Used by jbt_front, jbt_queue, jbt_back and json_byte_tokenizer.
// No dependencies.
package jbt_pkg;

  // Scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_NUM  = 3'd3,
    MODE_KW   = 3'd4
  } mode_t;

  // Token kinds
  localparam logic [3:0] TK_OBJ_OPEN  = 4'd0;
  localparam logic [3:0] TK_OBJ_CLOSE = 4'd1;
  localparam logic [3:0] TK_ARR_OPEN  = 4'd2;
  localparam logic [3:0] TK_ARR_CLOSE = 4'd3;
  localparam logic [3:0] TK_STRING    = 4'd4;
  localparam logic [3:0] TK_NUMBER    = 4'd5;
  localparam logic [3:0] TK_NULL      = 4'd6;

  // Event codes
  localparam logic [1:0] EV_WHOLE = 2'd0;
  localparam logic [1:0] EV_OPEN  = 2'd1;
  localparam logic [1:0] EV_BYTE  = 2'd2;
  localparam logic [1:0] EV_CLOSE = 2'd3;

  // Keyword ids
  localparam logic [1:0] KW_NULL  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_TRUE  = 2'd2;

  // Characters
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_LO_L   = 8'h6C;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_S   = 8'h73;
  localparam logic [7:0] CC_BS     = 8'h08;
  localparam logic [7:0] CC_FF     = 8'h0C;
  localparam logic [7:0] CC_LF     = 8'h0A;
  localparam logic [7:0] CC_CR     = 8'h0D;
  localparam logic [7:0] CC_TAB    = 8'h09;

  // Queue depth
  localparam int QDEPTH = 4;
  localparam int QPTRW  = $clog2(QDEPTH);

  // One result word
  typedef struct packed {
    logic [3:0] kind;
    logic [1:0] ev;
    logic [7:0] val;
  } result_t;

  // One queue entry: the results caused by one input word
  typedef struct packed {
    logic    two;
    result_t r1;
    result_t r0;
  } entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return is_digit(c) || c == CH_MINUS || c == CH_DOT || c == CH_LO_E || c == CH_UP_E;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_LO_B: r = CC_BS;
      CH_LO_F: r = CC_FF;
      CH_LO_N: r = CC_LF;
      CH_LO_R: r = CC_CR;
      CH_LO_T: r = CC_TAB;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] id);
    logic [2:0] r;
    case (id)
      KW_NULL:  r = 3'd4;
      KW_FALSE: r = 3'd5;
      KW_TRUE:  r = 3'd4;
      default:  r = 3'd0;
    endcase
    return r;
  endfunction

  // Expected keyword character; zero where the keyword has no such position
  function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    case (id)
      KW_NULL: begin
        case (pos)
          3'd0: r = CH_LO_N;
          3'd1: r = CH_LO_U;
          3'd2: r = CH_LO_L;
          3'd3: r = CH_LO_L;
          default: r = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (pos)
          3'd0: r = CH_LO_F;
          3'd1: r = CH_LO_A;
          3'd2: r = CH_LO_L;
          3'd3: r = CH_LO_S;
          3'd4: r = CH_LO_E;
          default: r = 8'h00;
        endcase
      end
      KW_TRUE: begin
        case (pos)
          3'd0: r = CH_LO_T;
          3'd1: r = CH_LO_R;
          3'd2: r = CH_LO_U;
          3'd3: r = CH_LO_E;
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/jbt_front.sv @@
// Front end of the JSON byte tokenizer: accepts input words, runs the scanner
// state and writes the results of each word into the queue as one entry.
// Depends on jbt_pkg.
module jbt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic [0:0]       in_tuser,   // [0] end_flag
  input  jbt_pkg::qstat_t  qstat,
  output logic             push,
  output jbt_pkg::entry_t  push_entry
);

  jbt_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     kw_id_r, kw_id_nxt;
  logic [2:0]     kw_pos_r, kw_pos_nxt;

  logic [7:0]     c;
  logic           accept;

  // Outcome of handling a byte from idle mode
  logic [1:0]       idle_n;
  jbt_pkg::result_t idle_r0, idle_r1;
  jbt_pkg::mode_t   idle_mode;
  logic             idle_kw;
  logic [1:0]       idle_kw_id;

  logic [1:0]       n;
  jbt_pkg::result_t r0, r1;
  logic             kw_match;

  assign c         = in_tdata;
  assign in_tready = !qstat.full;
  assign accept    = in_tvalid && in_tready;

  // Classify a byte as seen from idle mode
  always_comb begin
    idle_n     = 2'd0;
    idle_r0    = '0;
    idle_r1    = '0;
    idle_mode  = jbt_pkg::MODE_IDLE;
    idle_kw    = 1'b0;
    idle_kw_id = jbt_pkg::KW_NULL;
    if (c == jbt_pkg::CH_LBRACE) begin
      idle_n  = 2'd1;
      idle_r0 = '{jbt_pkg::TK_OBJ_OPEN, jbt_pkg::EV_WHOLE, 8'h00};
    end else if (c == jbt_pkg::CH_RBRACE) begin
      idle_n  = 2'd1;
      idle_r0 = '{jbt_pkg::TK_OBJ_CLOSE, jbt_pkg::EV_WHOLE, 8'h00};
    end else if (c == jbt_pkg::CH_LBRACK) begin
      idle_n  = 2'd1;
      idle_r0 = '{jbt_pkg::TK_ARR_OPEN, jbt_pkg::EV_WHOLE, 8'h00};
    end else if (c == jbt_pkg::CH_RBRACK) begin
      idle_n  = 2'd1;
      idle_r0 = '{jbt_pkg::TK_ARR_CLOSE, jbt_pkg::EV_WHOLE, 8'h00};
    end else if (c == jbt_pkg::CH_QUOTE) begin
      idle_n    = 2'd1;
      idle_r0   = '{jbt_pkg::TK_STRING, jbt_pkg::EV_OPEN, 8'h00};
      idle_mode = jbt_pkg::MODE_STR;
    end else if (c == jbt_pkg::CH_MINUS || jbt_pkg::is_digit(c)) begin
      idle_n    = 2'd2;
      idle_r0   = '{jbt_pkg::TK_NUMBER, jbt_pkg::EV_OPEN, 8'h00};
      idle_r1   = '{jbt_pkg::TK_NUMBER, jbt_pkg::EV_BYTE, c};
      idle_mode = jbt_pkg::MODE_NUM;
    end else if (c == jbt_pkg::CH_LO_N) begin
      idle_kw    = 1'b1;
      idle_kw_id = jbt_pkg::KW_NULL;
      idle_mode  = jbt_pkg::MODE_KW;
    end else if (c == jbt_pkg::CH_LO_F) begin
      idle_kw    = 1'b1;
      idle_kw_id = jbt_pkg::KW_FALSE;
      idle_mode  = jbt_pkg::MODE_KW;
    end else if (c == jbt_pkg::CH_LO_T) begin
      idle_kw    = 1'b1;
      idle_kw_id = jbt_pkg::KW_TRUE;
      idle_mode  = jbt_pkg::MODE_KW;
    end
  end

  assign kw_match = (kw_id_r <= jbt_pkg::KW_TRUE) && (kw_pos_r < jbt_pkg::kw_len(kw_id_r)) &&
                    (jbt_pkg::kw_char(kw_id_r, kw_pos_r) == c);

  // Next scanner state and results of this word
  always_comb begin
    mode_nxt   = mode_r;
    kw_id_nxt  = kw_id_r;
    kw_pos_nxt = kw_pos_r;
    n          = 2'd0;
    r0         = '0;
    r1         = '0;
    if (in_tuser[0]) begin
      // End of document: close an open literal, then return to reset
      if (mode_r == jbt_pkg::MODE_STR || mode_r == jbt_pkg::MODE_ESC) begin
        n  = 2'd1;
        r0 = '{jbt_pkg::TK_STRING, jbt_pkg::EV_CLOSE, 8'h00};
      end else if (mode_r == jbt_pkg::MODE_NUM) begin
        n  = 2'd1;
        r0 = '{jbt_pkg::TK_NUMBER, jbt_pkg::EV_CLOSE, 8'h00};
      end
      mode_nxt   = jbt_pkg::MODE_IDLE;
      kw_id_nxt  = 2'd0;
      kw_pos_nxt = 3'd0;
    end else begin
      unique case (mode_r)
        jbt_pkg::MODE_STR: begin
          if (c == jbt_pkg::CH_QUOTE) begin
            n        = 2'd1;
            r0       = '{jbt_pkg::TK_STRING, jbt_pkg::EV_CLOSE, 8'h00};
            mode_nxt = jbt_pkg::MODE_IDLE;
          end else if (c == jbt_pkg::CH_BSLASH) begin
            mode_nxt = jbt_pkg::MODE_ESC;
          end else begin
            n  = 2'd1;
            r0 = '{jbt_pkg::TK_STRING, jbt_pkg::EV_BYTE, c};
          end
        end
        jbt_pkg::MODE_ESC: begin
          n        = 2'd1;
          r0       = '{jbt_pkg::TK_STRING, jbt_pkg::EV_BYTE, jbt_pkg::unescape(c)};
          mode_nxt = jbt_pkg::MODE_STR;
        end
        jbt_pkg::MODE_NUM: begin
          if (jbt_pkg::is_num_char(c)) begin
            n  = 2'd1;
            r0 = '{jbt_pkg::TK_NUMBER, jbt_pkg::EV_BYTE, c};
          end else begin
            // Close the number, then handle the byte again from idle
            r0       = '{jbt_pkg::TK_NUMBER, jbt_pkg::EV_CLOSE, 8'h00};
            n        = (idle_n == 2'd0) ? 2'd1 : 2'd2;
            r1       = idle_r0;
            mode_nxt = idle_mode;
            if (idle_kw) begin
              kw_id_nxt  = idle_kw_id;
              kw_pos_nxt = 3'd1;
            end
          end
        end
        jbt_pkg::MODE_KW: begin
          if (!kw_match) begin
            // Drop the partial keyword, handle the byte again from idle
            n          = idle_n;
            r0         = idle_r0;
            r1         = idle_r1;
            mode_nxt   = idle_mode;
            kw_id_nxt  = idle_kw ? idle_kw_id : 2'd0;
            kw_pos_nxt = idle_kw ? 3'd1 : 3'd0;
          end else if (kw_pos_r + 3'd1 == jbt_pkg::kw_len(kw_id_r)) begin
            n          = 2'd1;
            r0         = '{jbt_pkg::TK_NULL + {2'b00, kw_id_r}, jbt_pkg::EV_WHOLE, 8'h00};
            mode_nxt   = jbt_pkg::MODE_IDLE;
            kw_id_nxt  = 2'd0;
            kw_pos_nxt = 3'd0;
          end else begin
            kw_pos_nxt = kw_pos_r + 3'd1;
          end
        end
        jbt_pkg::MODE_IDLE: begin
          n        = idle_n;
          r0       = idle_r0;
          r1       = idle_r1;
          mode_nxt = idle_mode;
          if (idle_kw) begin
            kw_id_nxt  = idle_kw_id;
            kw_pos_nxt = 3'd1;
          end
        end
        default: begin
          n          = idle_n;
          r0         = idle_r0;
          r1         = idle_r1;
          mode_nxt   = idle_mode;
          kw_id_nxt  = idle_kw ? idle_kw_id : 2'd0;
          kw_pos_nxt = idle_kw ? 3'd1 : 3'd0;
        end
      endcase
    end
  end

  // Write an entry only for words that cause results
  assign push           = accept && (n != 2'd0);
  assign push_entry.two = (n == 2'd2);
  assign push_entry.r0  = r0;
  assign push_entry.r1  = r1;

  // Advance scanner state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= jbt_pkg::MODE_IDLE;
      kw_id_r  <= 2'd0;
      kw_pos_r <= 3'd0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      kw_id_r  <= kw_id_nxt;
      kw_pos_r <= kw_pos_nxt;
    end
  end

endmodule

@@ rtl/jbt_queue.sv @@
// Short queue of result entries between the tokenizer front and back ends.
// Depends on jbt_pkg.
module jbt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jbt_pkg::entry_t  push_entry,
  input  logic             pop,
  output jbt_pkg::entry_t  head,
  output jbt_pkg::qstat_t  qstat
);

  jbt_pkg::entry_t mem_r [jbt_pkg::QDEPTH];

  logic [jbt_pkg::QPTRW-1:0] wr_ptr_r, rd_ptr_r;
  logic [jbt_pkg::QPTRW:0]   cnt_r, cnt_nxt;
  logic                      do_push, do_pop;

  assign qstat.full  = (cnt_r == (jbt_pkg::QPTRW+1)'(jbt_pkg::QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem_r[rd_ptr_r];

  // Track fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Write entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/jbt_back.sv @@
// Back end of the JSON byte tokenizer: unpacks queue entries into one result
// word per cycle unless out_tready stalls, held in the output register.
// Depends on jbt_pkg.
module jbt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  jbt_pkg::entry_t  head,
  input  jbt_pkg::qstat_t  qstat,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [7:0] value_byte
  output logic [5:0]       out_tuser,  // [3:0] token_kind, [5:4] event_res
  output logic             out_tlast   // last_of_run
);

  logic             valid_r, valid_nxt;
  logic             sel_r, sel_nxt;
  jbt_pkg::result_t res_r;
  logic             last_r;
  logic             slot_free, load, last_now;
  jbt_pkg::result_t pick;

  assign slot_free = !valid_r || out_tready;
  assign load      = slot_free && !qstat.empty;
  assign pick      = sel_r ? head.r1 : head.r0;
  assign last_now  = sel_r || !head.two;
  assign pop       = load && last_now;

  // Step through the results of the head entry
  always_comb begin
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    if (slot_free) begin
      valid_nxt = !qstat.empty;
    end
    if (load) begin
      sel_nxt = !last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Load the output payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= pick;
      last_r <= last_now;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.val;
  assign out_tuser  = {res_r.ev, res_r.kind};
  assign out_tlast  = last_r;

endmodule

@@ rtl/json_byte_tokenizer.sv @@
// JSON byte tokenizer top level: front end, result queue and back end.
// A result word passes through the queue and the output register before it leaves the block.
// Throughput: one input word per cycle unless the queue is full; one result word per cycle
// leaves the output register while out_tready is high; a four-entry queue absorbs double results.
// Reset: synchronous, active low; clears scanner state, queue and output valid.
// Depends on jbt_pkg, jbt_front, jbt_queue and jbt_back.
module json_byte_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  input  logic [0:0] in_tuser,    // [0] end_flag
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] value_byte
  output logic [5:0] out_tuser,   // [3:0] token_kind, [5:4] event_res
  output logic       out_tlast    // last_of_run
);

  jbt_pkg::qstat_t qstat;
  jbt_pkg::entry_t push_entry, head;
  logic            push, pop;

  jbt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  jbt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  jbt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
